>>> src/ttl_lru_cache_evictor_macros.svh
// Assertion macros used by the evictor top level.
`ifndef TTL_LRU_CACHE_EVICTOR_MACROS_SVH
`define TTL_LRU_CACHE_EVICTOR_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define TLCE_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TLCE_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

>>> src/tlce_pkg.sv
// Package with shared types and constants of the TTL/LRU cache evictor.
`default_nettype none
package tlce_pkg;
    localparam int ENTRIES = 32;
    localparam int IDX_W = 5;
    localparam int TOK_W = 20;
    localparam int TIME_W = 64;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_SWEEP = 2'd1;
    localparam logic [1:0] MODE_IDLE  = 2'd2;

    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_EVICT   = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    localparam logic [1:0] CAUSE_NONE    = 2'd0;
    localparam logic [1:0] CAUSE_EXPIRED = 2'd1;
    localparam logic [1:0] CAUSE_LRU     = 2'd2;

    localparam logic [1:0] REG_TTL      = 2'd0;
    localparam logic [1:0] REG_FALLBACK = 2'd1;
    localparam logic [1:0] REG_TARGET   = 2'd2;
    localparam logic [1:0] REG_IDLE     = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_DECIDE, ST_EMIT, ST_SUMMARY
    } state_t;

    typedef struct packed {
        logic        busy;
        logic [19:0] tokens;
        logic [63:0] used;
    } entry_t;
endpackage
`default_nettype wire

>>> src/ttl_lru_cache_evictor.sv
// Top level of the TTL/LRU cache evictor: control, valid bits and output stage.
`default_nettype none
`include "ttl_lru_cache_evictor_macros.svh"
// The block keeps 32 cache entries in a synchronous table. A mode 0 beat
// writes one entry and is acknowledged with an ack beat. A mode 1 beat sweeps:
// each victim is found by a scan over all 32 entries, one table read per
// cycle; a new scan follows each eviction. Mode 2 takes one scan and evicts
// at most one entry. Entries that were never written read as reset values
// through per-entry valid bits, so no clearing pass is needed after reset.
// Output beats wait in a register; one beat is presented at a time.
module ttl_lru_cache_evictor (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [61:0]  cfg_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // mode[1:0], entry_index[6:2], busy_req[7], token_count[27:8],
    // used_time[90:28], now_time[152:91], zero fill to 160 bits
    input  wire logic [159:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // victim_index[4:0], freed_tokens[24:5], cause[26:25],
    // evicted_count[32:27], total_freed[58:33], zero fill to 64 bits
    output logic [63:0]       m_tdata,
    // kind[1:0]
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);
    logic [61:0] ttl_reg, idle_reg;
    logic        fb_reg;
    logic [25:0] target_reg;
    logic [31:0] valid_reg;

    tlce_pkg::state_t state_reg, state_next;
    logic [1:0]  mode_reg;
    logic [61:0] now_reg;
    logic [5:0]  cnt_reg;
    logic [4:0]  ptr_reg;
    logic        rd_pend_reg;
    logic [4:0]  rd_idx_reg;
    logic        have_reg, best_exp_reg;
    logic [4:0]  best_reg;
    logic [63:0] best_used_reg;
    logic [19:0] best_tok_reg;
    logic [5:0]  ecount_reg;
    logic [25:0] total_reg;

    logic        ov_reg;
    logic [63:0] od_reg;
    logic [1:0]  ou_reg;
    logic        ol_reg;

    logic        we;
    logic [4:0]  waddr, raddr;
    tlce_pkg::entry_t wdata, rdata, ent;
    logic        in_acc;

    assign in_acc = s_tvalid && s_tready;
    assign s_tready = (state_reg == tlce_pkg::ST_IDLE) && !ov_reg;
    assign raddr = ptr_reg;

    tlce_table u_table (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // Entries never written read as their reset values.
    always_comb
    begin
        if (valid_reg[rd_idx_reg])
        begin
            ent = rdata;
        end
        else
        begin
            ent = '{busy: 1'b0, tokens: '0, used: '1};
        end
    end

    // Candidate qualification and ordering against the running best.
    logic [63:0] age;
    logic        neg, cand, expd, idle_ok, better;
    always_comb
    begin
        age = {2'b00, now_reg} - ent.used;
        neg = ent.used[63];
        cand = !ent.busy && (ent.tokens != '0);
        expd = (ttl_reg != '0) && !neg && ($signed(age) > $signed({2'b00, ttl_reg}));
        idle_ok = cand && !neg && !($signed(age) < $signed({2'b00, idle_reg}));
        if (!have_reg)
        begin
            better = 1'b1;
        end
        else if (expd != best_exp_reg)
        begin
            better = expd;
        end
        else
        begin
            better = $signed(ent.used) < $signed(best_used_reg);
        end
    end

    logic scan_hit;
    assign scan_hit = rd_pend_reg && ((mode_reg == tlce_pkg::MODE_SWEEP) ? (cand && better)
                                     : (idle_ok && !have_reg));

    // Only a sweep holds back unexpired victims; an idle eviction always goes.
    logic evict_ok;
    always_comb
    begin
        evict_ok = have_reg;
        if (have_reg && !best_exp_reg && mode_reg == tlce_pkg::MODE_SWEEP)
        begin
            if (!fb_reg)
            begin
                evict_ok = 1'b0;
            end
            else if ((target_reg != '0) && (total_reg >= target_reg))
            begin
                evict_ok = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tlce_pkg::ST_IDLE:
            begin
                if (in_acc && (s_tdata[1:0] == tlce_pkg::MODE_SWEEP
                               || s_tdata[1:0] == tlce_pkg::MODE_IDLE))
                begin
                    state_next = tlce_pkg::ST_SCAN;
                end
            end
            tlce_pkg::ST_SCAN:
            begin
                if (!rd_pend_reg && cnt_reg == 6'd32)
                begin
                    state_next = tlce_pkg::ST_DECIDE;
                end
            end
            tlce_pkg::ST_DECIDE:
            begin
                state_next = evict_ok ? tlce_pkg::ST_EMIT : tlce_pkg::ST_SUMMARY;
            end
            tlce_pkg::ST_EMIT:
            begin
                if (!ov_reg)
                begin
                    state_next = (mode_reg == tlce_pkg::MODE_SWEEP) ? tlce_pkg::ST_SCAN
                                                                     : tlce_pkg::ST_SUMMARY;
                end
            end
            tlce_pkg::ST_SUMMARY:
            begin
                if (!ov_reg)
                begin
                    state_next = tlce_pkg::ST_IDLE;
                end
            end
            default: state_next = tlce_pkg::ST_IDLE;
        endcase
    end

    // Table write: entry writes, or clearing the victim's busy flag and token count.
    always_comb
    begin
        we = 1'b0;
        waddr = s_tdata[6:2];
        wdata = '{busy: s_tdata[7], tokens: s_tdata[27:8],
                  used: {s_tdata[90], s_tdata[90:28]}};
        if (in_acc && s_tdata[1:0] == tlce_pkg::MODE_WRITE)
        begin
            we = 1'b1;
        end
        else if (state_reg == tlce_pkg::ST_EMIT && !ov_reg)
        begin
            we = 1'b1;
            waddr = best_reg;
            wdata = '{busy: 1'b0, tokens: '0, used: best_used_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg <= '0;
            fb_reg <= 1'b0;
            target_reg <= '0;
            idle_reg <= '0;
            valid_reg <= '0;
            state_reg <= tlce_pkg::ST_IDLE;
            ov_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            cnt_reg <= '0;
            ptr_reg <= '0;
            have_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tlce_pkg::REG_TTL:      ttl_reg <= cfg_data;
                    tlce_pkg::REG_FALLBACK: fb_reg <= cfg_data[0];
                    tlce_pkg::REG_TARGET:   target_reg <= cfg_data[25:0];
                    tlce_pkg::REG_IDLE:     idle_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (ov_reg && m_tready)
            begin
                ov_reg <= 1'b0;
            end
            rd_pend_reg <= (state_reg == tlce_pkg::ST_SCAN) && (cnt_reg != 6'd32);
            if (in_acc)
            begin
                if (s_tdata[1:0] == tlce_pkg::MODE_SWEEP || s_tdata[1:0] == tlce_pkg::MODE_IDLE)
                begin
                    cnt_reg <= '0;
                    ptr_reg <= '0;
                    have_reg <= 1'b0;
                end
                else
                begin
                    ov_reg <= 1'b1;
                end
            end
            if (state_reg == tlce_pkg::ST_SCAN)
            begin
                if (cnt_reg != 6'd32)
                begin
                    ptr_reg <= ptr_reg + 5'd1;
                    cnt_reg <= cnt_reg + 6'd1;
                end
                if (scan_hit)
                begin
                    have_reg <= 1'b1;
                end
            end
            if (state_reg == tlce_pkg::ST_EMIT && !ov_reg)
            begin
                ov_reg <= 1'b1;
                have_reg <= 1'b0;
                cnt_reg <= '0;
                ptr_reg <= '0;
            end
            if (state_reg == tlce_pkg::ST_SUMMARY && !ov_reg)
            begin
                ov_reg <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= ptr_reg;
        if (in_acc)
        begin
            mode_reg <= s_tdata[1:0];
            now_reg <= s_tdata[152:91];
            ecount_reg <= '0;
            total_reg <= '0;
            od_reg <= '0;
            ou_reg <= tlce_pkg::KIND_ACK;
            ol_reg <= 1'b1;
        end
        if (state_reg == tlce_pkg::ST_SCAN && scan_hit)
        begin
            best_reg <= rd_idx_reg;
            best_exp_reg <= (mode_reg == tlce_pkg::MODE_SWEEP) ? expd : 1'b0;
            best_used_reg <= ent.used;
            best_tok_reg <= ent.tokens;
        end
        if (state_reg == tlce_pkg::ST_EMIT && !ov_reg)
        begin
            od_reg <= {5'd0, 26'd0, 6'd0,
                       best_exp_reg ? tlce_pkg::CAUSE_EXPIRED : tlce_pkg::CAUSE_LRU,
                       best_tok_reg, best_reg};
            ou_reg <= tlce_pkg::KIND_EVICT;
            ol_reg <= 1'b0;
            ecount_reg <= ecount_reg + 6'd1;
            total_reg <= total_reg + {6'd0, best_tok_reg};
        end
        if (state_reg == tlce_pkg::ST_SUMMARY && !ov_reg)
        begin
            od_reg <= {5'd0, total_reg, ecount_reg, tlce_pkg::CAUSE_NONE, 20'd0, 5'd0};
            ou_reg <= tlce_pkg::KIND_SUMMARY;
            ol_reg <= 1'b1;
        end
    end

    // rd_idx tracks the entry whose data arrives this cycle.
    assign m_tvalid = ov_reg;
    assign m_tdata = od_reg;
    assign m_tuser = ou_reg;
    assign m_tlast = ol_reg;

    `TLCE_ASSERT_IMP(a_no_accept_busy, clk, rst_n,
        state_reg != tlce_pkg::ST_IDLE, !s_tready)
    `TLCE_ASSERT_IMP(a_emit_has_victim, clk, rst_n,
        state_reg == tlce_pkg::ST_EMIT, have_reg)
    `TLCE_ASSERT_NXT(a_decide_to_out, clk, rst_n,
        state_reg == tlce_pkg::ST_DECIDE,
        state_reg == tlce_pkg::ST_EMIT || state_reg == tlce_pkg::ST_SUMMARY)
endmodule
`default_nettype wire

>>> src/tlce_table.sv
// Entry table memory with one write and one registered read port.
`default_nettype none
module tlce_table (
    input  wire logic                   clk,
    input  wire logic                   we,
    input  wire logic [4:0]             waddr,
    input  wire tlce_pkg::entry_t       wdata,
    input  wire logic [4:0]             raddr,
    output tlce_pkg::entry_t            rdata
);
    tlce_pkg::entry_t mem [tlce_pkg::ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire
